// ===== src/psct_pkg.sv =====
// Shared constants and codes for the peer storage credit table.
`timescale 1ns / 1ps

package psct_pkg;

  localparam int unsigned MaxPeersDefault  = 256;
  localparam int unsigned KeyWidth         = 256;
  localparam int unsigned CountWidth       = 64;
  localparam int unsigned ApbAddrWidth     = 4;
  localparam int unsigned ApbDataWidth     = 64;

  localparam logic [CountWidth-1:0] NewPeerLimitReset = 64'd104857600;

  // Register index, taken from paddr above the 8-byte offset
  localparam logic [0:0] RegNewPeerLimit = 1'b0;

  // Operation codes
  localparam logic [1:0] OpRecordUs   = 2'd0;
  localparam logic [1:0] OpRecordThem = 2'd1;
  localparam logic [1:0] OpQuery      = 2'd2;

  // Status codes
  localparam logic [1:0] StatusDone    = 2'd0;
  localparam logic [1:0] StatusIgnored = 2'd1;
  localparam logic [1:0] StatusFull    = 2'd2;

  typedef logic [KeyWidth-1:0] psct_key_t;

  typedef struct packed {
    logic [CountWidth-1:0] held_for_us;
    logic [CountWidth-1:0] held_for_them;
  } psct_ctr_t;

endpackage

// ===== src/peer_storage_credit_table.sv =====
// Peer storage credit table: key search, counter update and acceptance query.
//
// One transaction is taken while busy is low and start is high; busy then
// stays high until the single result appears on status_o, accept_o and
// peer_known_o for one cycle with done_o high. The result cannot be stalled.
// A transaction that misses walks every stored entry (an empty table skips the
// search), and one that finds the peer stops at its index: the key memory has
// one read port and the search walks it one entry per cycle. A new transaction
// can be taken at the edge that ends the result cycle.
// Keys and counters live in two synchronous memories, written when a peer
// entry is created or a counter is updated; no clearing pass is needed.
`timescale 1ns / 1ps

module peer_storage_credit_table #(
  parameter int unsigned MAX_PEERS = psct_pkg::MaxPeersDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation_i,
  input  logic [psct_pkg::CountWidth-1:0]     key_word0_i,
  input  logic [psct_pkg::CountWidth-1:0]     key_word1_i,
  input  logic [psct_pkg::CountWidth-1:0]     key_word2_i,
  input  logic [psct_pkg::CountWidth-1:0]     key_word3_i,
  input  logic [psct_pkg::CountWidth-1:0]     byte_count_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic                                accept_o,
  output logic                                peer_known_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psct_pkg::ApbAddrWidth-1:0]   paddr,
  input  logic [psct_pkg::ApbDataWidth-1:0]   pwdata,
  output logic [psct_pkg::ApbDataWidth-1:0]   prdata,
  output logic                                pready
);

  import psct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PEERS + 1);
  localparam int unsigned IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCtrWait,
    StExec
  } state_e;

  state_e                state_q, state_d;
  logic [1:0]            op_q, op_d;
  psct_key_t             key_q, key_d;
  logic [CountWidth-1:0] bytes_q, bytes_d;
  logic [CW-1:0]         addr_q, addr_d;
  logic [CW-1:0]         cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IW-1:0]         slot_q, slot_d;
  logic                  hit_q, hit_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CountWidth-1:0] limit_q, limit_d;
  logic                  done_q, done_d;
  logic [1:0]            status_q, status_d;
  logic                  accept_q, accept_d;
  logic                  known_q, known_d;

  psct_key_t             key_mem [MAX_PEERS];
  psct_ctr_t             ctr_mem [MAX_PEERS];
  psct_key_t             key_rd_q;
  psct_ctr_t             ctr_rd_q;

  logic                  mem_we;
  logic                  key_we;
  logic [IW-1:0]         wr_addr;
  psct_ctr_t             ctr_wdata;

  logic                  cfg_we;
  logic                  is_record;
  logic                  room;
  logic [CountWidth-1:0] cur_us;
  logic [CountWidth-1:0] cur_them;
  logic [CountWidth-1:0] would;
  logic [CountWidth-1:0] us_sum;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[ApbAddrWidth-1:3] == RegNewPeerLimit);
  assign prdata = (paddr[ApbAddrWidth-1:3] == RegNewPeerLimit) ? limit_q : '0;

  assign busy         = (state_q != StIdle);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign accept_o     = accept_q;
  assign peer_known_o = known_q;

  // Execute-stage datapath; a missing peer reads as a zeroed entry
  assign is_record = (op_q == OpRecordUs) || (op_q == OpRecordThem);
  assign room      = (count_q < CW'(MAX_PEERS));
  assign cur_us    = hit_q ? ctr_rd_q.held_for_us : '0;
  assign cur_them  = hit_q ? ctr_rd_q.held_for_them : '0;
  assign would     = cur_them + bytes_q;
  assign us_sum    = cur_us + bytes_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    bytes_d   = bytes_q;
    addr_d    = addr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    slot_d    = slot_q;
    hit_d     = hit_q;
    count_d   = count_q;
    limit_d   = cfg_we ? pwdata : limit_q;
    done_d    = 1'b0;
    status_d  = status_q;
    accept_d  = accept_q;
    known_d   = known_q;
    mem_we    = 1'b0;
    key_we    = 1'b0;
    wr_addr   = hit_q ? slot_q : count_q[IW-1:0];
    ctr_wdata = '{held_for_us: cur_us, held_for_them: cur_them};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          op_d    = operation_i;
          key_d   = {key_word3_i, key_word2_i, key_word1_i, key_word0_i};
          bytes_d = byte_count_i;
          addr_d  = '0;
          hit_d   = 1'b0;
          state_d = (count_q == '0) ? StExec : StScan;
        end
      end
      StScan: begin
        // issue the next key read while comparing the previous one
        if (addr_q < count_q) begin
          addr_d    = addr_q + CW'(1);
          cmp_idx_d = addr_q;
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q && (key_rd_q == key_q)) begin
          hit_d     = 1'b1;
          slot_d    = cmp_idx_q[IW-1:0];
          cmp_vld_d = 1'b0;
          state_d   = StCtrWait;
        end else if (cmp_vld_q && (cmp_idx_q == count_q - CW'(1))) begin
          cmp_vld_d = 1'b0;
          state_d   = StExec;
        end
      end
      StCtrWait: begin
        state_d = StExec;
      end
      StExec: begin
        done_d   = 1'b1;
        known_d  = hit_q;
        status_d = StatusDone;
        accept_d = 1'b0;
        if (is_record) begin
          if (bytes_q == '0) begin
            status_d = StatusIgnored;
          end else if (!hit_q && !room) begin
            status_d = StatusFull;
          end else begin
            mem_we = 1'b1;
            key_we = !hit_q;
            if (!hit_q) begin
              count_d = count_q + CW'(1);
            end
            if (op_q == OpRecordUs) begin
              ctr_wdata.held_for_us = us_sum;
            end else begin
              ctr_wdata.held_for_them = would;
            end
          end
        end else if (op_q == OpQuery) begin
          if (!hit_q) begin
            accept_d = (bytes_q <= limit_q);
          end else if (cur_us == '0) begin
            accept_d = (would <= limit_q);
          end else begin
            // doubled at 65 bits so it cannot wrap
            accept_d = !({cur_us, 1'b0} < {1'b0, would});
          end
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      limit_q   <= NewPeerLimitReset;
      done_q    <= 1'b0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      status_q  <= StatusDone;
      accept_q  <= 1'b0;
      known_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      limit_q   <= limit_d;
      done_q    <= done_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      status_q  <= status_d;
      accept_q  <= accept_d;
      known_q   <= known_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    bytes_q   <= bytes_d;
    addr_q    <= addr_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
  end

  // Key memory: one read port walked by the search, written on entry creation
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_q;
    end
    key_rd_q <= key_mem[addr_q[IW-1:0]];
  end

  // Counter memory: read at the matched slot, written back in the execute cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ctr_mem[wr_addr] <= ctr_wdata;
    end
    ctr_rd_q <= ctr_mem[slot_q];
  end

  a_done_follows_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_count_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CW'(MAX_PEERS))
    else $error("entry count beyond table size");

  a_count_steps: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count changed by other than one");

  a_start_takes: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule
